/* rtl/ssb_pkg.sv */
// Shared widths, codes and register indexes for the subset-sum search core.
`default_nettype none
package ssb_pkg;

  localparam int SUM_W      = 20;  // running, remaining and target sums
  localparam int COUNT_W    = 5;   // element_count register
  localparam int MODE_W     = 2;
  localparam int INDEX_W    = 4;
  localparam int WEIGHT_W   = 16;  // weight_value payload field
  localparam int MASK_W     = 16;  // subset_mask result field
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SUM    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'b1;

  localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RESET = 5'd16;

endpackage
`default_nettype wire

/* rtl/ssb_req_if.sv */
// Request channel: load, restart and next-solution items.
`default_nettype none
interface ssb_req_if;
  import ssb_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [INDEX_W-1:0]  index;
  logic [WEIGHT_W-1:0] weight_value;

  modport source (output valid, output mode, output index, output weight_value,
                  input ready);
  modport sink   (input valid, input mode, input index, input weight_value,
                  output ready);
endinterface
`default_nettype wire

/* rtl/ssb_rsp_if.sv */
// Result channel: found subset or exhausted indication.
`default_nettype none
interface ssb_rsp_if;
  import ssb_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [MASK_W-1:0] subset_mask;
  logic              exhausted;

  modport source (output valid, output found, output subset_mask, output exhausted,
                  input ready);
  modport sink   (input valid, input found, input subset_mask, input exhausted,
                  output ready);
endinterface
`default_nettype wire

/* rtl/ssb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/subset_sum_backtrack_search_core.sv */
// Top level of the sum-of-subsets backtracking search core.
`default_nettype none
// Depth-first sum-of-subsets search over up to ELEMENTS weights held in a
// one-port-read weight RAM. A load writes one weight into the RAM. A restart
// streams the weights of the n active elements out of the RAM into the
// remaining total. A next-solution request visits tree nodes and takes
// backtrack steps until it finds a subset or climbs back to the root and
// reports the answer exhausted; a full output register stalls it. Every
// node and every backtrack step waits for the registered RAM read of its
// weight. Requests are taken only between operations; a finished result
// waits in the output register while the following loads or restarts are
// accepted. Weights are expected in ascending order for exact pruning.
module subset_sum_backtrack_search_core #(
  parameter int ELEMENTS    = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ssb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssb_pkg::CFG_DATA_W-1:0]   cfg_data,
  ssb_req_if.sink                               req,
  ssb_rsp_if.source                             rsp
);
  import ssb_pkg::*;

  localparam int AW = $clog2(ELEMENTS);
  localparam int LW = $clog2(ELEMENTS + 1);
  localparam int CW = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SUM      = 6'b000010,
    S_NODE_RD  = 6'b000100,
    S_NODE_EV  = 6'b001000,
    S_CLIMB_RD = 6'b010000,
    S_CLIMB_UP = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [SUM_W-1:0]     target_sum;
  logic [COUNT_W-1:0]   element_count;
  logic [LW-1:0]        active, active_next;
  logic [LW-1:0]        depth, depth_next;
  logic [LW-1:0]        cnt, cnt_next;
  logic                 pend, pend_next;
  logic [SUM_W-1:0]     running, running_next;
  logic [SUM_W-1:0]     remaining, remaining_next;
  logic [ELEMENTS-1:0]  inc, inc_next;
  logic                 search_over, search_over_next;
  logic                 after_found, after_found_next;
  logic                 out_valid, out_valid_next;
  logic                 out_found, out_found_next;
  logic [MASK_W-1:0]    out_mask, out_mask_next;
  logic                 out_exh, out_exh_next;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_wdata, ram_rdata;

  logic [LW-1:0]    n_clamp;
  logic [AW-1:0]    lvl_addr, up_addr;
  logic [SUM_W-1:0] w_sum;
  logic [CW-1:0]    sr_c, sw_c, tgt_c;
  logic             node_ok, out_free, accept;

  ssb_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (ELEMENTS)
  ) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.subset_mask = out_mask;
  assign rsp.exhausted   = out_exh;
  assign out_free        = !out_valid || rsp.ready;

  assign ram_we    = accept && (req.mode == MODE_LOAD) && (32'(req.index) < ELEMENTS);
  assign ram_waddr = AW'(req.index);
  assign ram_wdata = WEIGHT_BITS'(req.weight_value);

  always_comb begin
    if (element_count == '0) begin
      n_clamp = LW'(1);
    end else if (32'(element_count) > ELEMENTS) begin
      n_clamp = LW'(ELEMENTS);
    end else begin
      n_clamp = LW'(element_count);
    end
  end

  assign lvl_addr = (32'(depth) < ELEMENTS) ? AW'(depth) : '0;
  assign up_addr  = AW'(depth - LW'(1));
  assign w_sum    = SUM_W'(ram_rdata);
  assign tgt_c    = CW'(target_sum);
  assign sr_c     = CW'(running) + CW'(remaining);
  assign sw_c     = CW'(running) + CW'(ram_rdata);
  // Bound test; beyond the last active level only an exact hit passes.
  assign node_ok  = (sr_c >= tgt_c) &&
                    ((running == target_sum) || ((depth < active) && (sw_c <= tgt_c)));

  always_comb begin
    state_next       = state;
    active_next      = active;
    depth_next       = depth;
    cnt_next         = cnt;
    pend_next        = pend;
    running_next     = running;
    remaining_next   = remaining;
    inc_next         = inc;
    search_over_next = search_over;
    after_found_next = after_found;
    out_valid_next   = out_valid && !rsp.ready;
    out_found_next   = out_found;
    out_mask_next    = out_mask;
    out_exh_next     = out_exh;
    ram_re           = 1'b0;
    ram_raddr        = lvl_addr;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.mode)
            MODE_RESTART: begin
              active_next      = n_clamp;
              remaining_next   = '0;
              running_next     = '0;
              inc_next         = '0;
              depth_next       = '0;
              search_over_next = 1'b0;
              cnt_next         = '0;
              pend_next        = 1'b0;
              state_next       = S_SUM;
            end
            MODE_NEXT: begin
              after_found_next = 1'b0;
              state_next       = S_NODE_RD;
            end
            default: begin
            end
          endcase
        end
      end

      S_SUM: begin
        // read of entry cnt overlaps accumulation of entry cnt-1
        if (pend) begin
          remaining_next = remaining + w_sum;
        end
        if (cnt != active) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(cnt);
          cnt_next  = cnt + LW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = S_IDLE;
          end
        end
      end

      S_NODE_RD: begin
        if (search_over) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            out_found_next = 1'b0;
            out_mask_next  = '0;
            out_exh_next   = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = lvl_addr;
          state_next = S_NODE_EV;
        end
      end

      S_NODE_EV: begin
        if (!node_ok) begin
          state_next = S_CLIMB_RD;
        end else if (running == target_sum) begin
          if (out_free) begin
            out_valid_next   = 1'b1;
            out_found_next   = 1'b1;
            out_mask_next    = MASK_W'(inc);
            out_exh_next     = 1'b0;
            after_found_next = 1'b1;
            state_next       = S_CLIMB_RD;
          end
        end else begin
          inc_next[lvl_addr] = 1'b1;
          running_next       = running + w_sum;
          remaining_next     = remaining - w_sum;
          depth_next         = depth + LW'(1);
          state_next         = S_NODE_RD;
        end
      end

      S_CLIMB_RD: begin
        if (depth == '0) begin
          search_over_next = 1'b1;
          state_next       = after_found ? S_IDLE : S_NODE_RD;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = up_addr;
          state_next = S_CLIMB_UP;
        end
      end

      S_CLIMB_UP: begin
        if (inc[up_addr]) begin
          // switch the included branch to its exclude sibling
          inc_next[up_addr] = 1'b0;
          running_next      = running - w_sum;
          state_next        = after_found ? S_IDLE : S_NODE_RD;
        end else begin
          remaining_next = remaining + w_sum;
          depth_next     = depth - LW'(1);
          state_next     = S_CLIMB_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      target_sum    <= '0;
      element_count <= ELEMENT_COUNT_RESET;
      active        <= LW'(1);
      depth         <= '0;
      cnt           <= '0;
      pend          <= 1'b0;
      running       <= '0;
      remaining     <= '0;
      inc           <= '0;
      search_over   <= 1'b1;
      after_found   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state       <= state_next;
      active      <= active_next;
      depth       <= depth_next;
      cnt         <= cnt_next;
      pend        <= pend_next;
      running     <= running_next;
      remaining   <= remaining_next;
      inc         <= inc_next;
      search_over <= search_over_next;
      after_found <= after_found_next;
      out_valid   <= out_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_SUM:    target_sum    <= SUM_W'(cfg_data);
          REG_ELEMENT_COUNT: element_count <= COUNT_W'(cfg_data);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_found <= out_found_next;
    out_mask  <= out_mask_next;
    out_exh   <= out_exh_next;
  end

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("search state not one-hot");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= active)
    else $error("search depth beyond active element count");

  a_restart_arms: assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == MODE_RESTART) |=> (!search_over && state == S_SUM))
    else $error("restart did not arm the search");

  a_exh_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.exhausted) |-> (!rsp.found && rsp.subset_mask == '0))
    else $error("exhausted result carries a subset");

  a_result_only_on_next: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> ($past(state) == S_NODE_RD || $past(state) == S_NODE_EV))
    else $error("result issued outside a next-solution search");
`endif

endmodule
`default_nettype wire
